/* hdl/charge_state_detector_core_macros.svh */
// Assertion macros shared by the charge state detector RTL.
`ifndef CHARGE_STATE_DETECTOR_CORE_MACROS_SVH
`define CHARGE_STATE_DETECTOR_CORE_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define CSD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked on every clock edge, reset included.
`define CSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/csd_pkg.sv */
// Shared widths, register indexes, reset values and types of the charge state detector.
package csd_pkg;

   localparam int VoltWidth     = 13;
   localparam int DeltaWidth    = 10;
   localparam int IntervalWidth = 16;
   localparam int HoldWidth     = 16;
   localparam int TimeWidth     = 32;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 16;

   // Register indexes of the configuration port.
   localparam logic [CsrIndexWidth-1:0] CSR_VALID_FLOOR   = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_USB_THRESHOLD = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_CV_THRESHOLD  = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_RISE_DELTA    = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_RISE_INTERVAL = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_HOLD          = 3'd5;

   // Values after reset.
   localparam logic [VoltWidth-1:0]     RST_VALID_FLOOR   = 13'd100;
   localparam logic [VoltWidth-1:0]     RST_USB_THRESHOLD = 13'd3450;
   localparam logic [VoltWidth-1:0]     RST_CV_THRESHOLD  = 13'd4100;
   localparam logic [DeltaWidth-1:0]    RST_RISE_DELTA    = 10'd12;
   localparam logic [IntervalWidth-1:0] RST_RISE_INTERVAL = 16'd3000;
   localparam logic [HoldWidth-1:0]     RST_HOLD          = 16'd15000;

   typedef struct packed {
      logic [VoltWidth-1:0]     valid_floor_mv;
      logic [VoltWidth-1:0]     usb_threshold_mv;
      logic [VoltWidth-1:0]     cv_threshold_mv;
      logic [DeltaWidth-1:0]    rise_delta_mv;
      logic [IntervalWidth-1:0] rise_interval_ms;
      logic [HoldWidth-1:0]     hold_ms;
   } csd_cfg_type;

endpackage

/* hdl/charge_state_detector_core.sv */
// Top level of the charge state detector: input register, detection and result register.
// A beat passes through the input register and then the result register.
// Throughput: one beat per cycle unless rsp_ready stalls; reference and hold state update
// in the same cycle that the sample leaves the input register, so each sample sees its predecessor's state.
// Reset (synchronous, active high) loads the default configuration and clears the
// reference, the hold deadline and both stage valid flags.
`include "charge_state_detector_core_macros.svh"

module charge_state_detector_core
   import csd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [VoltWidth-1:0]     req_voltage_mv,
   input  logic                     req_usb_mounted,
   input  logic [TimeWidth-1:0]     req_now_ms,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_charging,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_write_data
);

   csd_cfg_type cfg;

   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   logic [VoltWidth-1:0] s1_voltage_ff;
   logic                 s1_mounted_ff;
   logic [TimeWidth-1:0] s1_now_ff;
   logic                 s1_advance;
   logic                 charging;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 rsp_charging_ff;

   csd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   csd_detect u_detect (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .advance     (s1_advance),
      .voltage_mv  (s1_voltage_ff),
      .usb_mounted (s1_mounted_ff),
      .now_ms      (s1_now_ff),
      .charging    (charging)
   );

   // The input stage moves on when the result register is free or being emptied.
   assign s1_advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !s1_valid_ff || s1_advance;
   assign s1_valid_in  = req_ready ? req_valid : s1_valid_ff;
   assign rsp_valid_in = s1_advance || (rsp_valid_ff && !rsp_ready);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_voltage_ff <= req_voltage_mv;
         s1_mounted_ff <= req_usb_mounted;
         s1_now_ff     <= req_now_ms;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_charging_ff <= charging;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_charging = rsp_charging_ff;

   // A reading at or below the floor always answers not charging.
   `CSD_ASSERT(a_floor_not_charging, clock, reset,
      s1_advance && (s1_voltage_ff <= cfg.valid_floor_mv) |=> !rsp_charging,
      "reading at floor reported charging")
   // A valid reading at the constant-voltage threshold always answers charging.
   `CSD_ASSERT(a_cv_charging, clock, reset,
      s1_advance && (s1_voltage_ff > cfg.valid_floor_mv)
      && (s1_voltage_ff >= cfg.cv_threshold_mv) |=> rsp_charging,
      "reading at cv threshold not reported charging")
   // A sample held in the input stage is never dropped.
   `CSD_ASSERT(a_s1_kept, clock, reset,
      s1_valid_ff && !s1_advance |=> s1_valid_ff,
      "input stage beat lost")
   // A stalled result stays valid until taken.
   `CSD_ASSERT(a_rsp_kept, clock, reset,
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_charging_ff),
      "stalled result beat changed")
   // Reset empties the input register and the result register.
   `CSD_ASSERT_ALWAYS(a_reset_empty, clock,
      reset |=> !rsp_valid_ff && !s1_valid_ff,
      "pipeline not empty after reset")

endmodule

/* hdl/csd_csr.sv */
// Configuration register file of the charge state detector.
module csd_csr
   import csd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_write_data,
   output csd_cfg_type              cfg
);

   csd_cfg_type cfg_ff;
   csd_cfg_type cfg_in;

   // Decode the register index and merge the written field.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_VALID_FLOOR:   cfg_in.valid_floor_mv   = csr_write_data[VoltWidth-1:0];
            CSR_USB_THRESHOLD: cfg_in.usb_threshold_mv = csr_write_data[VoltWidth-1:0];
            CSR_CV_THRESHOLD:  cfg_in.cv_threshold_mv  = csr_write_data[VoltWidth-1:0];
            CSR_RISE_DELTA:    cfg_in.rise_delta_mv    = csr_write_data[DeltaWidth-1:0];
            CSR_RISE_INTERVAL: cfg_in.rise_interval_ms = csr_write_data[IntervalWidth-1:0];
            CSR_HOLD:          cfg_in.hold_ms          = csr_write_data[HoldWidth-1:0];
            default: begin
               // Unused indexes are ignored.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.valid_floor_mv   <= RST_VALID_FLOOR;
         cfg_ff.usb_threshold_mv <= RST_USB_THRESHOLD;
         cfg_ff.cv_threshold_mv  <= RST_CV_THRESHOLD;
         cfg_ff.rise_delta_mv    <= RST_RISE_DELTA;
         cfg_ff.rise_interval_ms <= RST_RISE_INTERVAL;
         cfg_ff.hold_ms          <= RST_HOLD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hdl/csd_detect.sv */
// Detection logic with the reference sample and hold deadline state.
module csd_detect
   import csd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  csd_cfg_type          cfg,
   input  logic                 advance,
   input  logic [VoltWidth-1:0] voltage_mv,
   input  logic                 usb_mounted,
   input  logic [TimeWidth-1:0] now_ms,
   output logic                 charging
);

   logic [VoltWidth-1:0] reference_mv_ff;
   logic [VoltWidth-1:0] reference_mv_in;
   logic [TimeWidth-1:0] reference_time_ms_ff;
   logic [TimeWidth-1:0] reference_time_ms_in;
   logic [TimeWidth-1:0] hold_deadline_ms_ff;
   logic [TimeWidth-1:0] hold_deadline_ms_in;

   logic                 reading_ok;
   logic                 by_threshold;
   logic                 has_reference;
   logic [TimeWidth-1:0] reference_age;
   logic                 reference_aged;
   logic [VoltWidth:0]   rise_limit;
   logic                 rose;
   logic                 take_reference;
   logic                 detected;
   logic [TimeWidth-1:0] hold_left;
   logic                 hold_active;

   // Threshold tests and the rise test against the stored reference.
   always_comb begin
      reading_ok     = voltage_mv > cfg.valid_floor_mv;
      by_threshold   = (usb_mounted && (voltage_mv > cfg.usb_threshold_mv))
                       || (voltage_mv >= cfg.cv_threshold_mv);
      has_reference  = reference_time_ms_ff != '0;
      reference_age  = now_ms - reference_time_ms_ff;
      reference_aged = reference_age
                       >= {{(TimeWidth-IntervalWidth){1'b0}}, cfg.rise_interval_ms};
      rise_limit     = {1'b0, reference_mv_ff}
                       + {{(VoltWidth+1-DeltaWidth){1'b0}}, cfg.rise_delta_mv};
      rose           = {1'b0, voltage_mv} > rise_limit;
      take_reference = by_threshold || !has_reference || reference_aged;
      detected       = by_threshold || (has_reference && reference_aged && rose);
      hold_left      = hold_deadline_ms_ff - now_ms;
      hold_active    = (hold_left != '0) && !hold_left[TimeWidth-1];
      charging       = reading_ok && (detected || hold_active);
   end

   // State changes only for a valid reading that moves on.
   always_comb begin
      reference_mv_in      = reference_mv_ff;
      reference_time_ms_in = reference_time_ms_ff;
      hold_deadline_ms_in  = hold_deadline_ms_ff;
      if (advance && reading_ok) begin
         if (take_reference) begin
            reference_mv_in      = voltage_mv;
            reference_time_ms_in = now_ms;
         end
         if (detected) begin
            hold_deadline_ms_in = now_ms + {{(TimeWidth-HoldWidth){1'b0}}, cfg.hold_ms};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reference_mv_ff      <= '0;
         reference_time_ms_ff <= '0;
         hold_deadline_ms_ff  <= '0;
      end else begin
         reference_mv_ff      <= reference_mv_in;
         reference_time_ms_ff <= reference_time_ms_in;
         hold_deadline_ms_ff  <= hold_deadline_ms_in;
      end
   end

endmodule
